// ===== rtl/core/crl_pkg.sv =====
// Shared types and constants for the connection rate limiter.
// Depends on nothing; imported by crl_ctrl, crl_dp and the top-level unit.
`timescale 1ns / 1ps

package crl_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	localparam int ADDR_W     = 32;
	localparam int TIME_W     = 48;
	localparam int WINDOW_W   = 16;
	localparam int BAN_W      = 32;
	localparam int STRIKE_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [WINDOW_W-1:0] WINDOW_RST      = 16'd650;
	localparam logic [BAN_W-1:0]    SHORT_BAN_RST   = 32'd10000;
	localparam logic [BAN_W-1:0]    LONG_BAN_RST    = 32'd20000;
	localparam logic [STRIKE_W-1:0] STRIKE_LIM_RST  = 8'd4;
	localparam logic [ADDR_W-1:0]   ALLOW_ADDR_RST  = 32'h0509_AD76;
	localparam logic                ALLOW_EN_RST    = 1'b1;
	localparam logic [STRIKE_W-1:0] STRIKE_MAX      = '1;
	localparam logic [TIME_W-1:0]   TIME_MAX        = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW     = 3'd0,
		CFG_SHORT_BAN  = 3'd1,
		CFG_LONG_BAN   = 3'd2,
		CFG_STRIKE_LIM = 3'd3,
		CFG_ALLOW_ADDR = 3'd4,
		CFG_ALLOW_EN   = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		VERDICT_KNOWN  = 3'd0,
		VERDICT_NEW    = 3'd1,
		VERDICT_WHITE  = 3'd2,
		VERDICT_NOADDR = 3'd3,
		VERDICT_BANNED = 3'd4,
		VERDICT_FAST   = 3'd5
	} verdict_t;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_CLASSIFY = 3'd1,
		ST_SCAN     = 3'd2,
		ST_EVAL     = 3'd3,
		ST_UPDATE   = 3'd4
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   address;
		logic [TIME_W-1:0]   last_time;
		logic [TIME_W-1:0]   ban_until;
		logic [STRIKE_W-1:0] strikes;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic     load;
		logic     scan;
		logic     take_hit;
		logic     insert;
		logic     eval;
		logic     update;
		logic     emit;
		verdict_t verdict;
	} dp_cmd_t;

	typedef struct packed {
		logic present;
		logic white;
		logic hit;
		logic miss;
		logic banned;
		logic fast;
	} dp_status_t;

endpackage

// ===== rtl/core/crl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module crl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/crl_ctrl.sv =====
// Controller state machine for the connection rate limiter.
// Depends on crl_pkg; drives crl_dp through command/status structs.
`timescale 1ns / 1ps

module crl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  crl_pkg::dp_status_t status,
	output crl_pkg::dp_cmd_t    cmd
);
	import crl_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CLASSIFY;
			end
			ST_CLASSIFY: begin
				if (!status.present || status.white) state_d = ST_IDLE;
				else state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.hit) state_d = ST_EVAL;
				else if (status.miss) state_d = ST_IDLE;
			end
			ST_EVAL: begin
				if (status.banned) state_d = ST_IDLE;
				else state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.verdict = VERDICT_KNOWN;
		busy        = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_CLASSIFY: begin
				if (!status.present) begin
					cmd.emit    = 1'b1;
					cmd.verdict = VERDICT_NOADDR;
				end else if (status.white) begin
					cmd.emit    = 1'b1;
					cmd.verdict = VERDICT_WHITE;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.hit) begin
					cmd.take_hit = 1'b1;
				end else if (status.miss) begin
					cmd.insert  = 1'b1;
					cmd.emit    = 1'b1;
					cmd.verdict = VERDICT_NEW;
				end
			end
			ST_EVAL: begin
				if (status.banned) begin
					cmd.emit    = 1'b1;
					cmd.verdict = VERDICT_BANNED;
				end else begin
					cmd.eval = 1'b1;
				end
			end
			ST_UPDATE: begin
				cmd.update  = 1'b1;
				cmd.emit    = 1'b1;
				cmd.verdict = status.fast ? VERDICT_FAST : VERDICT_KNOWN;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ===== rtl/core/crl_dp.sv =====
// Datapath: config registers, address table, scan, ban and strike arithmetic.
// Depends on crl_pkg and crl_ram; commanded by crl_ctrl.
`timescale 1ns / 1ps

module crl_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [crl_pkg::ADDR_W-1:0]     source_address,
	input  logic                           address_present,
	input  logic [crl_pkg::TIME_W-1:0]     now_ms,
	input  logic                           cfg_write,
	input  logic [crl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  crl_pkg::dp_cmd_t               cmd,
	output crl_pkg::dp_status_t            status,
	output logic                           done,
	output logic                           admit,
	output logic [2:0]                     verdict,
	output logic                           table_full
);
	import crl_pkg::*;

	logic [WINDOW_W-1:0] window_q;
	logic [BAN_W-1:0]    short_ban_q;
	logic [BAN_W-1:0]    long_ban_q;
	logic [STRIKE_W-1:0] strike_lim_q;
	logic [ADDR_W-1:0]   allow_addr_q;
	logic                allow_en_q;

	logic [ADDR_W-1:0]   addr_q;
	logic                present_q;
	logic [TIME_W-1:0]   now_q;

	logic [CNT_W-1:0]    fill_q;
	logic [CNT_W-1:0]    issue_q;
	logic                pend_s1;
	logic [IDX_W-1:0]    pend_idx_s1;
	logic [IDX_W-1:0]    hit_idx_q;
	entry_t              ent_q;
	logic                fast_q;
	logic [STRIKE_W-1:0] strike_q;

	logic                done_q;
	logic                admit_q;
	verdict_t            verdict_q;
	logic                full_q;

	logic                rd_en;
	logic [ENTRY_W-1:0]  rd_raw;
	entry_t              rd_ent;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	entry_t              wr_ent;
	logic                room;
	logic [TIME_W-1:0]   elapsed;
	logic [BAN_W-1:0]    ban_len;
	logic [TIME_W:0]     until_sum;
	logic [TIME_W-1:0]   until_sat;
	logic [STRIKE_W-1:0] strike_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= WINDOW_RST;
			short_ban_q  <= SHORT_BAN_RST;
			long_ban_q   <= LONG_BAN_RST;
			strike_lim_q <= STRIKE_LIM_RST;
			allow_addr_q <= ALLOW_ADDR_RST;
			allow_en_q   <= ALLOW_EN_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_WINDOW:     window_q     <= cfg_data[WINDOW_W-1:0];
				CFG_SHORT_BAN:  short_ban_q  <= cfg_data[BAN_W-1:0];
				CFG_LONG_BAN:   long_ban_q   <= cfg_data[BAN_W-1:0];
				CFG_STRIKE_LIM: strike_lim_q <= cfg_data[STRIKE_W-1:0];
				CFG_ALLOW_ADDR: allow_addr_q <= cfg_data[ADDR_W-1:0];
				CFG_ALLOW_EN:   allow_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Slots fill in order and are never freed: slot i is valid iff i < fill_q.
	assign room    = (fill_q != CNT_W'(TABLE_ENTRIES));
	assign rd_en   = cmd.scan && (issue_q < fill_q);
	assign rd_ent  = entry_t'(rd_raw);

	assign elapsed    = now_q - ent_q.last_time;
	assign strike_inc = (ent_q.strikes == STRIKE_MAX) ? STRIKE_MAX
	                                                  : ent_q.strikes + STRIKE_W'(1);
	assign ban_len    = (strike_q > strike_lim_q) ? long_ban_q : short_ban_q;
	assign until_sum  = {1'b0, now_q} + {{(TIME_W + 1 - BAN_W){1'b0}}, ban_len};
	assign until_sat  = until_sum[TIME_W] ? TIME_MAX : until_sum[TIME_W-1:0];

	always_comb begin
		wr_en           = 1'b0;
		wr_addr         = hit_idx_q;
		wr_ent.address  = addr_q;
		wr_ent.last_time = now_q;
		wr_ent.ban_until = '0;
		wr_ent.strikes  = '0;
		if (cmd.insert) begin
			wr_en   = room;
			wr_addr = fill_q[IDX_W-1:0];
		end else if (cmd.update) begin
			wr_en            = 1'b1;
			wr_ent.ban_until = fast_q ? until_sat : ent_q.ban_until;
			wr_ent.strikes   = fast_q ? strike_q : '0;
		end
	end

	crl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_ent),
		.rd_en  (rd_en),
		.rd_addr(issue_q[IDX_W-1:0]),
		.rd_data(rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			issue_q <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.load) begin
				issue_q <= '0;
				pend_s1 <= 1'b0;
			end else if (cmd.scan) begin
				pend_s1 <= rd_en;
				if (rd_en) issue_q <= issue_q + CNT_W'(1);
			end
			if (cmd.insert && room) fill_q <= fill_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q    <= source_address;
			present_q <= address_present;
			now_q     <= now_ms;
		end
		if (cmd.scan && rd_en) pend_idx_s1 <= issue_q[IDX_W-1:0];
		if (cmd.take_hit) begin
			hit_idx_q <= pend_idx_s1;
			ent_q     <= rd_ent;
		end
		if (cmd.eval) begin
			fast_q   <= (elapsed < {{(TIME_W - WINDOW_W){1'b0}}, window_q});
			strike_q <= strike_inc;
		end
		if (cmd.emit) begin
			verdict_q <= cmd.verdict;
			admit_q   <= (cmd.verdict == VERDICT_KNOWN) || (cmd.verdict == VERDICT_NEW) ||
			             (cmd.verdict == VERDICT_WHITE);
			full_q    <= cmd.insert && !room;
		end
	end

	assign status.present = present_q;
	assign status.white   = allow_en_q && (addr_q == allow_addr_q);
	assign status.hit     = pend_s1 && (rd_ent.address == addr_q);
	assign status.miss    = !pend_s1 && (issue_q == fill_q);
	assign status.banned  = ent_q.ban_until > now_q;
	assign status.fast    = fast_q;

	assign done       = done_q;
	assign admit      = admit_q;
	assign verdict    = verdict_q;
	assign table_full = full_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TABLE_ENTRIES))
		else $error("fill count beyond table size");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + CNT_W'(1)))
		else $error("fill count moved by other than one");

	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("two results in consecutive cycles");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q <= fill_q)
		else $error("scan read past last filled slot");

endmodule

// ===== rtl/core/connection_rate_limiter_unit.sv =====
// Top level of the per-source connection rate limiter.
// Depends on crl_pkg, crl_ctrl, crl_dp (which holds crl_ram).
//
// channel   direction  handshake             payload
// attempt   in         start & !busy         source_address, address_present, now_ms
// verdict   out        done (one cycle)      admit, verdict, table_full
// config    in         cfg_write             cfg_index, cfg_data
//
// An attempt with no address or an always-admitted source ends at classification;
// any other attempt scans the table until a hit or the end of the filled slots.
// The scan is linear over the 64-entry table RAM, one slot read per cycle
// through its single read port.
// Reset clears the table fill count; no clearing pass is needed.
// busy stays high from acceptance until the cycle the result strobe is raised.
// The receiver cannot stall: done is high for exactly one cycle per result.
`timescale 1ns / 1ps

module connection_rate_limiter_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [crl_pkg::ADDR_W-1:0]     source_address,
	input  logic                           address_present,
	input  logic [crl_pkg::TIME_W-1:0]     now_ms,
	input  logic                           cfg_write,
	input  logic [crl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crl_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           done,
	output logic                           admit,
	output logic [2:0]                     verdict,
	output logic                           table_full
);
	import crl_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	crl_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.status(status),
		.cmd   (cmd)
	);

	crl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.source_address (source_address),
		.address_present(address_present),
		.now_ms         (now_ms),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.status         (status),
		.done           (done),
		.admit          (admit),
		.verdict        (verdict),
		.table_full     (table_full)
	);

endmodule
